>>> src/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types, command codes and constants for the DCC packet builder.
// ----------------------------------------------------------------------------
package dcc_pkg;

   // command kinds on the request channel
   typedef enum logic [2:0] {
      KIND_IDLE   = 3'd0,
      KIND_RESET  = 3'd1,
      KIND_SPEED  = 3'd2,
      KIND_FUNC   = 3'd3,
      KIND_ACCESS = 3'd4,
      KIND_LOAD   = 3'd5
   } req_kind_type;

   localparam int FUNC_W   = 29;
   localparam int MAX_PKT  = 5;
   localparam int CNT_W    = 3;

   // CSR map: byte address, word index is paddr[2]
   localparam int   CSR_ADDR_W = 3;
   localparam logic CSR_IDX_OE = 1'b0;

   // packet constants
   localparam logic [7:0] BYTE_IDLE     = 8'hFF;
   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] BYTE_SPD128   = 8'h3F;
   localparam logic [7:0] BYTE_F13_F20  = 8'hDE;
   localparam logic [7:0] BYTE_F21_F28  = 8'hDF;
   localparam logic [6:0] SPEED_MAX     = 7'd127;
   localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;

   // function group bounds
   localparam logic [4:0] FN_GRP1_MAX = 5'd4;
   localparam logic [4:0] FN_GRP2_MAX = 5'd8;
   localparam logic [4:0] FN_GRP3_MAX = 5'd12;
   localparam logic [4:0] FN_GRP4_MAX = 5'd20;
   localparam logic [4:0] FN_MAX      = 5'd28;

   // one accepted command
   typedef struct packed {
      req_kind_type       kind;
      logic [13:0]        address;
      logic [7:0]         speed;
      logic               forward;
      logic [4:0]         func_number;
      logic               turn_on;
      logic [FUNC_W-1:0]  function_image;
   } dcc_cmd_type;

   // finished packet, checksum included; slot 0 goes out first
   typedef struct packed {
      logic [MAX_PKT-1:0][7:0] bytes;
      logic [CNT_W-1:0]        count;
   } dcc_pkt_type;

endpackage

>>> src/dcc_if.sv
// ----------------------------------------------------------------------------
// dcc_req_if / dcc_rsp_if
// Valid/ready channels for commands and packet bytes.
// ----------------------------------------------------------------------------
interface dcc_req_if import dcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        req_type;
   logic [13:0]       address;
   logic [7:0]        speed;
   logic              forward;
   logic [4:0]        func_number;
   logic              turn_on;
   logic [FUNC_W-1:0] function_image;

   modport source (output valid, req_type, address, speed, forward, func_number,
                   turn_on, function_image, input ready);
   modport sink   (input valid, req_type, address, speed, forward, func_number,
                   turn_on, function_image, output ready);
endinterface

interface dcc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source (output valid, packet_byte, last_byte, input ready);
   modport sink   (input valid, packet_byte, last_byte, output ready);
endinterface

>>> src/dcc_encoder.sv
// ----------------------------------------------------------------------------
// dcc_encoder
// Builds the packet bytes and checksum for one command; keeps the F0-F28 image.
// ----------------------------------------------------------------------------
module dcc_encoder import dcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic        output_enable,
   input  dcc_cmd_type cmd,
   output dcc_pkt_type pkt
);

   logic [FUNC_W-1:0] func_ff, func_in;
   logic [FUNC_W-1:0] fmask, img_upd, img_load;
   logic              active;
   logic [7:0]        h0, h1, b0, b1, chk;
   logic [1:0]        nh, nb;
   logic [3:0][7:0]   raw;
   logic [CNT_W-1:0]  n;
   logic [6:0]        spd;
   logic [8:0]        acc_a;

   assign active = output_enable;

   // mask of the image bit for the function number
   always_comb begin
      fmask = '0;
      if (cmd.func_number == 5'd0) begin
         fmask = FUNC_W'(1) << 4;
      end else if (cmd.func_number <= FN_GRP1_MAX) begin
         fmask = FUNC_W'(1) << (cmd.func_number - 5'd1);
      end else if (cmd.func_number <= FN_MAX) begin
         fmask = FUNC_W'(1) << cmd.func_number;
      end
   end

   assign img_upd  = cmd.turn_on ? (func_ff | fmask) : (func_ff & ~fmask);
   // F0 moves to bit four, F1..F4 to bits 0..3
   assign img_load = {cmd.function_image[FUNC_W-1:5], cmd.function_image[0],
                      cmd.function_image[4:1]};

   // function image update
   always_comb begin
      func_in = func_ff;
      if (fire) begin
         if (cmd.kind == KIND_LOAD) begin
            func_in = img_load;
         end else if (cmd.kind == KIND_FUNC && active) begin
            func_in = img_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= '0;
      end else begin
         func_ff <= func_in;
      end
   end

   // speed clamp, 1 maps to 2
   always_comb begin
      spd = cmd.speed[7] ? SPEED_MAX : cmd.speed[6:0];
      if (spd == 7'd1) begin
         spd = 7'd2;
      end
   end

   assign acc_a = cmd.address[10:2] + 9'd1;

   // header (locomotive address) and body bytes
   always_comb begin
      if (cmd.address > SHORT_ADDR_MAX) begin
         h0 = {2'b11, cmd.address[13:8]};
         h1 = cmd.address[7:0];
         nh = 2'd2;
      end else begin
         h0 = cmd.address[7:0];
         h1 = BYTE_ZERO;
         nh = 2'd1;
      end
      b0 = BYTE_ZERO;
      b1 = BYTE_ZERO;
      nb = 2'd2;
      unique case (cmd.kind)
         KIND_IDLE: begin
            nh = 2'd0;
            b0 = BYTE_IDLE;
         end
         KIND_RESET: begin
            nh = 2'd0;
         end
         KIND_SPEED: begin
            b0 = BYTE_SPD128;
            b1 = {cmd.forward, spd};
         end
         KIND_FUNC: begin
            nb = 2'd1;
            if (cmd.func_number <= FN_GRP1_MAX) begin
               b0 = {3'b100, img_upd[4:0]};
            end else if (cmd.func_number <= FN_GRP2_MAX) begin
               b0 = {4'hB, img_upd[8:5]};
            end else if (cmd.func_number <= FN_GRP3_MAX) begin
               b0 = {4'hA, img_upd[12:9]};
            end else if (cmd.func_number <= FN_GRP4_MAX) begin
               b0 = BYTE_F13_F20;
               b1 = img_upd[20:13];
               nb = 2'd2;
            end else begin
               b0 = BYTE_F21_F28;
               b1 = img_upd[28:21];
               nb = 2'd2;
            end
         end
         KIND_ACCESS: begin
            nh = 2'd0;
            b0 = {2'b10, acc_a[5:0]};
            b1 = {1'b1, ~acc_a[8:6], cmd.turn_on, cmd.address[1:0], 1'b0};
         end
         default: begin
            nh = 2'd0;
         end
      endcase
   end

   // pack header and body, count without checksum
   always_comb begin
      unique case (nh)
         2'd0:    raw = {BYTE_ZERO, BYTE_ZERO, b1, b0};
         2'd1:    raw = {BYTE_ZERO, b1, b0, h0};
         default: raw = {b1, b0, h1, h0};
      endcase
      if (nb == 2'd1) begin
         // single body byte: clear the slot the second one would take
         raw[2'(nh + 2'd1)] = BYTE_ZERO;
      end
   end

   assign chk = raw[0] ^ raw[1] ^ raw[2] ^ raw[3];

   // final packet with checksum in the slot right after the data bytes
   always_comb begin
      logic [CNT_W-1:0] nd;
      nd = CNT_W'(nh) + CNT_W'(nb);
      for (int i = 0; i < MAX_PKT; i++) begin
         if (i < 4 && CNT_W'(i) < nd) begin
            pkt.bytes[i] = raw[i % 4];
         end else if (CNT_W'(i) == nd) begin
            pkt.bytes[i] = chk;
         end else begin
            pkt.bytes[i] = BYTE_ZERO;
         end
      end
      n = nd + CNT_W'(1);
      if (!active || cmd.kind == KIND_LOAD || cmd.kind > KIND_LOAD) begin
         n = '0;
      end
      pkt.count = n;
   end

endmodule

>>> src/dcc_serializer.sv
// ----------------------------------------------------------------------------
// dcc_serializer
// Result register: holds one packet and sends it out one byte per item.
// ----------------------------------------------------------------------------
module dcc_serializer import dcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  dcc_pkt_type pkt,
   output logic        free,
   dcc_rsp_if.source   rsp
);

   logic [MAX_PKT-1:0][7:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    take;

   assign take = rsp.valid && rsp.ready;
   // free once empty, or when the final byte leaves this cycle
   assign free = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp.ready);

   // load or shift
   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         bytes_in = pkt.bytes;
         cnt_in   = pkt.count;
      end else if (take) begin
         for (int i = 0; i < MAX_PKT - 1; i++) begin
            bytes_in[i] = bytes_ff[i + 1];
         end
         bytes_in[MAX_PKT-1] = BYTE_ZERO;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp.valid       = (cnt_ff != '0);
   assign rsp.packet_byte = bytes_ff[0];
   assign rsp.last_byte   = (cnt_ff == CNT_W'(1));

endmodule

>>> src/dcc_command_packet_builder.sv
// The first packet byte is valid in the cycle after the command is accepted.
// One command per packet (3 to 5 bytes, checksum included); the next one is
//   taken as the last byte leaves, and commands with no bytes do not hold the
//   intake. The output register sends one byte per cycle while ready is high.
// Reset: synchronous, active high; clears the function image, output_enable
//   and the output byte count.
// ----------------------------------------------------------------------------
// dcc_command_packet_builder
// DCC packet builder top level: CSR port, encoder and byte serializer.
// ----------------------------------------------------------------------------
module dcc_command_packet_builder import dcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dcc_req_if.sink               req_bus,
   dcc_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic        oe_ff, oe_in;
   logic        csr_wr;
   logic        free;
   logic        req_fire;
   dcc_cmd_type cmd;
   dcc_pkt_type pkt;

   // CSR: output_enable
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      oe_in = oe_ff;
      if (csr_wr && csr_paddr[2] == CSR_IDX_OE) begin
         oe_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oe_ff <= 1'b0;
      end else begin
         oe_ff <= oe_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_OE) ? {31'd0, oe_ff} : 32'd0;

   // command intake
   assign req_bus.ready = free;
   assign req_fire      = req_bus.valid && free;

   assign cmd.kind           = req_kind_type'(req_bus.req_type);
   assign cmd.address        = req_bus.address;
   assign cmd.speed          = req_bus.speed;
   assign cmd.forward        = req_bus.forward;
   assign cmd.func_number    = req_bus.func_number;
   assign cmd.turn_on        = req_bus.turn_on;
   assign cmd.function_image = req_bus.function_image;

   dcc_encoder u_encoder (
      .clock         (clock),
      .reset         (reset),
      .fire          (req_fire),
      .output_enable (oe_ff),
      .cmd           (cmd),
      .pkt           (pkt)
   );

   dcc_serializer u_serializer (
      .clock (clock),
      .reset (reset),
      .load  (req_fire),
      .pkt   (pkt),
      .free  (free),
      .rsp   (rsp_bus)
   );

   // checks
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!rsp_bus.valid || (rsp_bus.ready && rsp_bus.last_byte)))
      else $error("command accepted over an unsent packet");

   a_disabled_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !oe_ff) |=> !rsp_bus.valid)
      else $error("bytes produced with output disabled");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.req_type == KIND_LOAD) |=> !rsp_bus.valid)
      else $error("image load produced bytes");

   a_idle_first: assert property (@(posedge clock) disable iff (reset)
      (req_fire && oe_ff && req_bus.req_type == KIND_IDLE)
      |=> (rsp_bus.valid && rsp_bus.packet_byte == BYTE_IDLE))
      else $error("idle packet does not start with FF");

endmodule
